### hdl/dns_qname_label_encoder_core_defines.svh
// Assertion macros used by the DNS name encoder controller.
`ifndef DNS_QNAME_LABEL_ENCODER_CORE_DEFINES_SVH
`define DNS_QNAME_LABEL_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, masked while rst_n is low.
`define DQLE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, masked while rst_n is low.
`define DQLE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/dqle_pkg.sv
// Types and constants of the DNS name encoder.
`default_nettype none
package dqle_pkg;

  localparam logic [7:0] DOT_CHAR    = 8'h2E;
  localparam logic [7:0] NUL_BYTE    = 8'h00;
  localparam logic [8:0] LIMIT_RESET = 9'd256;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NAME_LONG  = 2'd1;
  localparam logic [1:0] ST_LABEL_LONG = 2'd2;

  typedef logic [1:0] osel_t;
  localparam osel_t OSEL_LEN  = 2'd0;
  localparam osel_t OSEL_CHR  = 2'd1;
  localparam osel_t OSEL_ZERO = 2'd2;
  localparam osel_t OSEL_ERR  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  nc_inc;
    logic  set_err1;
    logic  set_err2;
    logic  store_chr;
    logic  out_ld;
    osel_t out_sel;
    logic  out_last;
    logic  rd_first;
    logic  rd_next;
    logic  lbl_clr;
    logic  name_clr;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_end;
    logic item_dot;
    logic err_pending;
    logic size_err_chr;
    logic size_err_end;
    logic label_full;
    logic cnt_zero;
    logic idx_last;
    logic slot_free;
  } dp_stat_t;

endpackage
`default_nettype wire

### hdl/dqle_in_if.sv
// Input channel: host name characters and end-of-name items.
`default_nettype none
interface dqle_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] char_byte;

  modport source (output valid, output cmd, output char_byte, input ready);
  modport sink   (input valid, input cmd, input char_byte, output ready);
endinterface
`default_nettype wire

### hdl/dqle_out_if.sv
// Output channel: encoded wire-format bytes with status.
`default_nettype none
interface dqle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic [1:0] status;

  modport source (output valid, output out_byte, output last_of_run, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input status,
                  output ready);
endinterface
`default_nettype wire

### hdl/dqle_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dqle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 62
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### hdl/dqle_ctrl.sv
// Controller state machine of the DNS name encoder.
`default_nettype none
`include "dns_qname_label_encoder_core_defines.svh"
module dqle_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dqle_pkg::dp_stat_t  st,
  output dqle_pkg::ctl_cmd_t       cmd
);
  import dqle_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LEN  = 3'd1;
  localparam logic [2:0] S_CHR  = 3'd2;
  localparam logic [2:0] S_TERM = 3'd3;
  localparam logic [2:0] S_ERR  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       is_end_r, is_end_nxt;
  logic       acc;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    is_end_nxt = is_end_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (!st.item_end) begin
            // drop characters while an error is pending
            if (!st.err_pending) begin
              cmd.nc_inc = 1'b1;
              if (st.size_err_chr) begin
                cmd.set_err1 = 1'b1;
              end else if (st.item_dot) begin
                is_end_nxt = 1'b0;
                state_nxt  = S_LEN;
              end else if (st.label_full) begin
                cmd.set_err2 = 1'b1;
              end else begin
                cmd.store_chr = 1'b1;
              end
            end
          end else if (st.err_pending || st.size_err_end) begin
            cmd.set_err1 = !st.err_pending;
            state_nxt    = S_ERR;
          end else begin
            is_end_nxt = 1'b1;
            state_nxt  = S_LEN;
          end
        end
      end
      S_LEN: begin
        if (st.slot_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_sel  = OSEL_LEN;
          cmd.out_last = !is_end_r && st.cnt_zero;
          cmd.rd_first = 1'b1;
          if (!st.cnt_zero) begin
            state_nxt = S_CHR;
          end else if (is_end_r) begin
            state_nxt = S_TERM;
          end else begin
            cmd.lbl_clr = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_CHR: begin
        if (st.slot_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_sel  = OSEL_CHR;
          cmd.out_last = !is_end_r && st.idx_last;
          cmd.rd_next  = 1'b1;
          if (st.idx_last) begin
            cmd.lbl_clr = 1'b1;
            state_nxt   = is_end_r ? S_TERM : S_IDLE;
          end
        end
      end
      S_TERM: begin
        if (st.slot_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_sel  = OSEL_ZERO;
          cmd.out_last = 1'b1;
          cmd.name_clr = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_ERR: begin
        if (st.slot_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_sel  = OSEL_ERR;
          cmd.out_last = 1'b1;
          cmd.name_clr = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      is_end_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      is_end_r <= is_end_nxt;
    end
  end

  `DQLE_ASSERT_NOW(a_ld_needs_slot, cmd.out_ld, st.slot_free, "output loaded while occupied")
  `DQLE_ASSERT_NEXT(a_err_end_to_err, acc && st.item_end && st.err_pending, state_r == S_ERR, "pending error not reported on end")
  `DQLE_ASSERT_NOW(a_chr_nonempty, state_r == S_CHR, !st.cnt_zero, "character burst with empty label")
  `DQLE_ASSERT_NEXT(a_close_to_idle, (state_r == S_TERM || state_r == S_ERR) && st.slot_free, state_r == S_IDLE && !st.err_pending, "name not closed after final byte")

endmodule
`default_nettype wire

### hdl/dqle_dpath.sv
// Datapath of the DNS name encoder: counters, label store and output register.
`default_nettype none
module dqle_dpath #(
  parameter int LABEL_MAX = 62
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [8:0]         cfg_wdata,
  input  wire logic               in_cmd,
  input  wire logic [7:0]         in_char_byte,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [7:0]              out_byte,
  output logic                    out_last_of_run,
  output logic [1:0]              out_status,
  input  wire dqle_pkg::ctl_cmd_t cmd,
  output dqle_pkg::dp_stat_t      st
);
  import dqle_pkg::*;

  localparam int CW = $clog2(LABEL_MAX + 1);
  localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

  logic [8:0]    limit_r;
  logic [8:0]    name_count_r;
  logic [CW-1:0] label_count_r;
  logic [CW-1:0] idx_r;
  logic [1:0]    error_code_r;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;
  logic [1:0]    out_status_r;

  logic [8:0]    nc_nxt;
  logic [CW-1:0] idx_inc;
  logic [7:0]    rd_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    byte_sel;
  logic [1:0]    status_sel;

  assign nc_nxt  = name_count_r + 9'd1;
  assign idx_inc = idx_r + CW'(1);

  assign st.item_end     = in_cmd;
  assign st.item_dot     = (in_char_byte == DOT_CHAR);
  assign st.err_pending  = (error_code_r != ST_OK);
  assign st.size_err_chr = ({1'b0, nc_nxt} + 10'd1) >= {1'b0, limit_r};
  assign st.size_err_end = ({1'b0, name_count_r} + 10'd1) >= {1'b0, limit_r};
  assign st.label_full   = (label_count_r == CW'(LABEL_MAX));
  assign st.cnt_zero     = (label_count_r == '0);
  assign st.idx_last     = (idx_inc == label_count_r);
  assign st.slot_free    = !out_valid_r || out_ready;

  // Prefetch the next character so it is ready when the output slot frees.
  assign rd_en   = (cmd.rd_first && !st.cnt_zero) || (cmd.rd_next && !st.idx_last);
  assign rd_addr = cmd.rd_first ? '0 : idx_inc[AW-1:0];

  dqle_ram #(
    .WIDTH (8),
    .DEPTH (LABEL_MAX)
  ) u_label_store (
    .clk   (clk),
    .we    (cmd.store_chr),
    .waddr (label_count_r[AW-1:0]),
    .wdata (in_char_byte),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    byte_sel   = NUL_BYTE;
    status_sel = ST_OK;
    case (cmd.out_sel)
      OSEL_LEN:  byte_sel = {{(8 - CW){1'b0}}, label_count_r};
      OSEL_CHR:  byte_sel = rd_data;
      OSEL_ZERO: byte_sel = NUL_BYTE;
      OSEL_ERR:  status_sel = error_code_r;
      default:   byte_sel = NUL_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r       <= LIMIT_RESET;
      name_count_r  <= '0;
      label_count_r <= '0;
      idx_r         <= '0;
      error_code_r  <= ST_OK;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (cmd.name_clr) begin
        name_count_r <= '0;
      end else if (cmd.nc_inc) begin
        name_count_r <= nc_nxt;
      end
      if (cmd.name_clr || cmd.lbl_clr) begin
        label_count_r <= '0;
      end else if (cmd.store_chr) begin
        label_count_r <= label_count_r + CW'(1);
      end
      if (cmd.rd_first) begin
        idx_r <= '0;
      end else if (cmd.rd_next) begin
        idx_r <= idx_inc;
      end
      if (cmd.name_clr) begin
        error_code_r <= ST_OK;
      end else if (cmd.set_err1) begin
        error_code_r <= ST_NAME_LONG;
      end else if (cmd.set_err2) begin
        error_code_r <= ST_LABEL_LONG;
      end
      // hold the result until the receiver takes the transfer
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_byte_r   <= byte_sel;
      out_last_r   <= cmd.out_last;
      out_status_r <= status_sel;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_status      = out_status_r;

endmodule
`default_nettype wire

### hdl/dns_qname_label_encoder_core.sv
// Top level of the DNS host name to wire-format encoder.
//
// in_ch carries one item per transfer: cmd 0 with a host name character in
// char_byte, or cmd 1 to end the name. out_ch carries encoded bytes: the
// length byte of each label, its characters, and a zero byte at the end of
// the name; last_of_run marks the final byte caused by one input item and
// status reports a name or label error on a single zero byte instead.
// cfg_we/cfg_wdata write the encoded size limit (reset 256).
// Plain characters are taken one per cycle while in_ch.ready is high and
// give no output. A dot gives label length + 1 output bytes (the length byte
// and the characters) unless an error is pending or it raises one; an end
// item gives label length + 2 bytes, or one byte when it reports an error.
// The byte loop is paced by the output register, fed by a label store whose
// registered read is prefetched one byte ahead. The first output byte loads
// in the state a dot or end enters. in_ch.ready is low while a label drains.
// Reset (synchronous, rst_n low) clears the counters, the error code and the
// output valid; the label store needs no clearing. When the receiver stalls,
// the output byte holds and the label burst pauses.
`default_nettype none
module dns_qname_label_encoder_core #(
  parameter int LABEL_MAX = 62
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  dqle_in_if.sink         in_ch,
  dqle_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_wdata
);
  import dqle_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t st;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  dqle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  dqle_dpath #(
    .LABEL_MAX (LABEL_MAX)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_cmd          (in_ch.cmd),
    .in_char_byte    (in_ch.char_byte),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_byte        (out_ch.out_byte),
    .out_last_of_run (out_ch.last_of_run),
    .out_status      (out_ch.status),
    .cmd             (cmd),
    .st              (st)
  );

endmodule
`default_nettype wire
